[rtl/chacha20_keystream_block_macros.svh]
// Assertion macros shared by the keystream block RTL.
// Included by the modules that carry concurrent checks; SYNTH removes them.
`ifndef CHACHA20_KEYSTREAM_BLOCK_MACROS_SVH
`define CHACHA20_KEYSTREAM_BLOCK_MACROS_SVH
`ifndef SYNTH
`define CC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CC_ASSERT(label, clk, rst_n, prop, msg)
`define CC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[rtl/cc20_pkg.sv]
// Types, constants and round functions of the ChaCha20 keystream block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cc20_pkg;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  // ASCII "expand 32-byte k", word 0 in the low slot.
  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef enum logic [2:0] {
    REG_KEY_0      = 3'd0,
    REG_KEY_1      = 3'd1,
    REG_KEY_2      = 3'd2,
    REG_KEY_3      = 3'd3,
    REG_NONCE_LOW  = 3'd4,
    REG_NONCE_HIGH = 3'd5
  } reg_e;

  // One add/xor/rotate step of the quarter round, applied to all four lanes.
  typedef enum logic [1:0] {
    STEP_A16 = 2'd0,
    STEP_C12 = 2'd1,
    STEP_A8  = 2'd2,
    STEP_C7  = 2'd3
  } step_e;

  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
  } cfg_t;

  typedef struct packed {
    state_t      w;
    logic [31:0] ctr;
  } stage_t;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t init_state(cfg_t cfg, logic [31:0] ctr);
    state_t s;
    for (int i = 0; i < 4; i++) begin
      s[i]         = SIGMA[i];
      s[4 + 2 * i] = cfg.key[i][31:0];
      s[5 + 2 * i] = cfg.key[i][63:32];
    end
    s[12] = ctr;
    s[13] = cfg.nonce_low[31:0];
    s[14] = cfg.nonce_low[63:32];
    s[15] = cfg.nonce_high;
    return s;
  endfunction

  function automatic state_t qr_step(state_t w, logic diag, step_e phase);
    state_t      r;
    logic [3:0]  a;
    logic [3:0]  b;
    logic [3:0]  c;
    logic [3:0]  d;
    logic [31:0] s;
    r = w;
    for (int q = 0; q < 4; q++) begin
      a = 4'(q);
      if (diag) begin
        b = 4'(4 + ((q + 1) & 3));
        c = 4'(8 + ((q + 2) & 3));
        d = 4'(12 + ((q + 3) & 3));
      end else begin
        b = 4'(4 + q);
        c = 4'(8 + q);
        d = 4'(12 + q);
      end
      case (phase)
        STEP_A16: begin
          s    = w[a] + w[b];
          r[a] = s;
          r[d] = rotl(w[d] ^ s, 16);
        end
        STEP_C12: begin
          s    = w[c] + w[d];
          r[c] = s;
          r[b] = rotl(w[b] ^ s, 12);
        end
        STEP_A8: begin
          s    = w[a] + w[b];
          r[a] = s;
          r[d] = rotl(w[d] ^ s, 8);
        end
        default: begin
          s    = w[c] + w[d];
          r[c] = s;
          r[b] = rotl(w[b] ^ s, 7);
        end
      endcase
    end
    return r;
  endfunction

endpackage

[rtl/cc20_cfg.sv]
// APB register file holding the key and nonce of the keystream block.
// Depends on cc20_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module cc20_cfg import cc20_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [3:0][63:0] key_q, key_d;
  logic [63:0]      nonce_low_q, nonce_low_d;
  logic [31:0]      nonce_high_q, nonce_high_d;
  logic             wr_en;
  reg_e             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[5:3]);

  always_comb begin
    key_d        = key_q;
    nonce_low_d  = nonce_low_q;
    nonce_high_d = nonce_high_q;
    if (wr_en) begin
      case (reg_sel)
        REG_KEY_0:      key_d[0]     = pwdata;
        REG_KEY_1:      key_d[1]     = pwdata;
        REG_KEY_2:      key_d[2]     = pwdata;
        REG_KEY_3:      key_d[3]     = pwdata;
        REG_NONCE_LOW:  nonce_low_d  = pwdata;
        REG_NONCE_HIGH: nonce_high_d = pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_0:      prdata = key_q[0];
      REG_KEY_1:      prdata = key_q[1];
      REG_KEY_2:      prdata = key_q[2];
      REG_KEY_3:      prdata = key_q[3];
      REG_NONCE_LOW:  prdata = nonce_low_q;
      REG_NONCE_HIGH: prdata = {32'd0, nonce_high_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      nonce_low_q  <= '0;
      nonce_high_q <= '0;
    end else begin
      key_q        <= key_d;
      nonce_low_q  <= nonce_low_d;
      nonce_high_q <= nonce_high_d;
    end
  end

  assign cfg_o = '{key: key_q, nonce_low: nonce_low_q, nonce_high: nonce_high_q};

endmodule

[rtl/cc20_round_stage.sv]
// One pipeline stage: a single add/xor/rotate step of four quarter rounds.
// Depends on cc20_pkg for the state types and the step function.
`timescale 1ns / 1ps

module cc20_round_stage import cc20_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  stage_t data_i,
  input  logic   diag_i,
  input  step_e  phase_i,
  output logic   valid_o,
  output stage_t data_o
);

  logic   valid_q;
  stage_t data_q, data_d;

  always_comb begin
    data_d.w   = qr_step(data_i.w, diag_i, phase_i);
    data_d.ctr = data_i.ctr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/cc20_serializer.sv]
// Final feed-forward add and the output buffer that sends one block as eight words.
// Depends on cc20_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`include "chacha20_keystream_block_macros.svh"

module cc20_serializer import cc20_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  stage_t      data_i,
  output logic        take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] keystream_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic       valid_q, valid_d;
  logic [2:0] cnt_q, cnt_d;
  state_t     blk_q, blk_d;
  state_t     init_w;
  logic       take;

  // A new block may load once the buffer is empty or its last word transfers.
  assign take   = !valid_q || (out_ready_i && (cnt_q == 3'd7));
  assign init_w = init_state(cfg_i, data_i.ctr);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk_d[i] = data_i.w[i] + init_w[i];
    end
  end

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (take) begin
      valid_d = valid_i;
      cnt_d   = 3'd0;
    end else if (out_ready_i) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign take_o           = take;
  assign out_valid_o      = valid_q;
  assign keystream_word_o = {blk_q[{cnt_q, 1'b1}], blk_q[{cnt_q, 1'b0}]};
  assign word_index_o     = cnt_q;
  assign last_word_o      = (cnt_q == 3'd7);

  `CC_ASSERT(a_word_advance, clk_i, rst_ni, out_valid_o && out_ready_i && !last_word_o |=> out_valid_o && (word_index_o == $past(word_index_o) + 3'd1), "word index did not advance within a block")
  `CC_ASSERT(a_block_starts_at_zero, clk_i, rst_ni, $rose(out_valid_o) |-> word_index_o == 3'd0, "block did not start at word zero")
  `CC_ASSERT(a_no_early_load, clk_i, rst_ni, out_valid_o && !last_word_o |-> !take_o, "buffer reloaded in the middle of a block")

endmodule

[rtl/chacha20_keystream_block.sv]
// ChaCha20 keystream block: the 20-round block function of RFC 7539, fully pipelined.
// Turns each block counter into 64 keystream bytes, given as eight 64-bit little-endian
// words with word_index_o 0..7 and last_word_o on the eighth. Key and nonce sit in
// APB registers at byte addresses 0, 8, 16, 24 (key), 32 (nonce words 0 and 1) and
// 40 (nonce word 2); write them only while the block holds no counter in flight.
// The rounds run in 8 * DOUBLE_ROUNDS register stages (one add/xor/rotate step of
// four quarter rounds each). A counter passes through them, then the output buffer
// registers its finished block, from which the first word can transfer. The buffer
// sends one word per cycle while out_ready_i is high and can load the next block as
// the last word transfers. The pipeline moves as a whole: while its last stage is
// empty it keeps accepting counters, but a finished block waiting there stalls every
// stage and the input until the buffer takes it. There is no clearing pass after reset.
// Depends on cc20_pkg, cc20_cfg, cc20_round_stage, cc20_serializer and the macros header.
`timescale 1ns / 1ps
`include "chacha20_keystream_block_macros.svh"

module chacha20_keystream_block import cc20_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       block_counter_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       keystream_word_o,
  output logic [2:0]        word_index_o,
  output logic              last_word_o
);

  localparam int unsigned NSTAGE = 8 * DOUBLE_ROUNDS;

  cfg_t            cfg;
  stage_t          pipe_data [0:NSTAGE];
  logic [NSTAGE:0] pipe_v;
  logic            take;
  logic            adv;

  cc20_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The whole pipeline moves together; it stalls only when its last stage is full
  // and the output buffer cannot take that block.
  assign adv        = !pipe_v[NSTAGE] || take;
  assign in_ready_o = adv;

  assign pipe_v[0]        = in_valid_i;
  assign pipe_data[0].w   = init_state(cfg, block_counter_i);
  assign pipe_data[0].ctr = block_counter_i;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    localparam logic [2:0] SEL = 3'(g % 8);
    cc20_round_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (pipe_v[g]),
      .data_i  (pipe_data[g]),
      .diag_i  (SEL[2]),
      .phase_i (step_e'(SEL[1:0])),
      .valid_o (pipe_v[g+1]),
      .data_o  (pipe_data[g+1])
    );
  end

  cc20_serializer u_ser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (pipe_v[NSTAGE]),
    .data_i           (pipe_data[NSTAGE]),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .keystream_word_o (keystream_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  `CC_ASSERT_ALWAYS(a_empty_buffer_never_blocks, clk_i, !out_valid_o |-> in_ready_o, "pipeline stalled with an empty output buffer")
  `CC_ASSERT(a_stalled_block_holds, clk_i, rst_ni, pipe_v[NSTAGE] && !take |=> pipe_v[NSTAGE] && $stable(pipe_data[NSTAGE].ctr), "stalled block was lost or changed")
  `CC_ASSERT(a_drain_when_empty, clk_i, rst_ni, out_valid_o && out_ready_i && last_word_o && !pipe_v[NSTAGE] |=> !out_valid_o, "output buffer invented a block")

endmodule
